// File: rtl/ddc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddc_pkg: shared types, constants and helpers of the down-converter
// Fixed-point constants, register map, CORDIC angle table and the
// elaboration-time tap generator for the windowed-sinc tap ROM.
// ----------------------------------------------------------------------------
package ddc_pkg;

  localparam int TAP_COUNT_DEF       = 65;
  localparam int MAX_DECIMATION_DEF  = 16;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam int PHASE_W      = 32;
  localparam int NCO_W        = 16;
  localparam int TAP_W        = 18;
  localparam int OUT_W        = 24;
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_ITERS = 24;
  localparam int ITER_W       = 5;

  localparam longint CORDIC_GAIN_Q30 = 652032874;
  localparam longint INV_PI_Q30      = 341782638;
  localparam longint HAM_A_Q30       = 579820585;
  localparam longint HAM_B_Q30       = 493921239;

  // APB map: word-aligned, byte lanes ignored, bit 2 picks the register
  localparam int PADDR_W = 3;
  localparam logic REG_PHASE_STEP = 1'b0;
  localparam logic REG_DECIM      = 1'b1;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               produce;
  } item_ctl_t;

  function automatic logic [CORDIC_W-1:0] atan_q30(input logic [ITER_W-1:0] idx);
    logic [CORDIC_W-1:0] a;
    unique case (idx)
      5'd0:  a = CORDIC_W'(536870912);
      5'd1:  a = CORDIC_W'(316933406);
      5'd2:  a = CORDIC_W'(167458907);
      5'd3:  a = CORDIC_W'(85004756);
      5'd4:  a = CORDIC_W'(42667331);
      5'd5:  a = CORDIC_W'(21354465);
      5'd6:  a = CORDIC_W'(10679838);
      5'd7:  a = CORDIC_W'(5340245);
      5'd8:  a = CORDIC_W'(2670163);
      5'd9:  a = CORDIC_W'(1335087);
      5'd10: a = CORDIC_W'(667544);
      5'd11: a = CORDIC_W'(333772);
      5'd12: a = CORDIC_W'(166886);
      5'd13: a = CORDIC_W'(83443);
      5'd14: a = CORDIC_W'(41722);
      5'd15: a = CORDIC_W'(20861);
      default: a = CORDIC_W'(longint'(683565276) >> idx);
    endcase
    return a;
  endfunction

  function automatic longint rnd_l(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // shift-subtract divide, used only while building constants
  function automatic longint unsigned udiv_l(input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint cordic_l(input logic [PHASE_W-1:0] ph, input bit want_sin);
    logic [1:0]         qd;
    bit                 flip;
    logic [PHASE_W-1:0] p;
    longint             x, y, z, a, dx, dy;
    qd   = ph[31:30];
    flip = (qd == 2'd1) || (qd == 2'd2);
    p    = flip ? ph + 32'h8000_0000 : ph;
    z    = longint'(signed'(p));
    x    = CORDIC_GAIN_Q30;
    y    = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      a  = longint'(atan_q30(ITER_W'(i)));
      dx = x >>> i;
      dy = y >>> i;
      if (z >= 0) begin
        x = x - dy; y = y + dx; z = z - a;
      end else begin
        x = x + dy; y = y - dx; z = z + a;
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    return want_sin ? y : x;
  endfunction

  function automatic logic signed [TAP_W-1:0] tap_coef(input int d, input int n,
                                                       input int taps);
    longint hist, m, am, sinc, num, s30, c30, w, h, hr;
    logic [PHASE_W-1:0] ph;
    hist = taps - 1;
    m    = n - (hist >> 1);
    am   = (m < 0) ? -m : m;
    if (m == 0) begin
      sinc = longint'(udiv_l((longint'(1) << 30) + (d >> 1), d));
    end else begin
      ph   = PHASE_W'(udiv_l((am << 32) + d, 2 * d));
      s30  = cordic_l(ph, 1'b1);
      num  = rnd_l(s30 * INV_PI_Q30, 30);
      sinc = (num < 0) ? -longint'(udiv_l(-num, am)) : longint'(udiv_l(num, am));
    end
    ph  = PHASE_W'(udiv_l((longint'(n) << 32) + (hist >> 1), hist));
    c30 = cordic_l(ph, 1'b0);
    w   = HAM_A_Q30 - rnd_l(HAM_B_Q30 * c30, 30);
    h   = rnd_l(sinc * w, 30);
    hr  = rnd_l(h, 13);
    if (hr > 131071) hr = 131071;
    if (hr < -131072) hr = -131072;
    return TAP_W'(hr);
  endfunction

endpackage

// File: rtl/digital_down_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digital_down_converter_unit: NCO mixer, complex FIR low-pass, decimator
// Mixes each complex sample down by an NCO, filters it with a
// Hamming-windowed sinc chosen by the decimation factor, and emits one
// saturated Q1.23 word per decimation period.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | sink      | in_valid_i / in_stall_o   | in_i_i, in_q_i, block_last_i
//  out     | source    | out_valid_o / out_stall_i | out_i_o, out_q_o
//  cfg     | APB slave | psel/penable/pready       | paddr, pwdata, prdata
//
//  A word runs through the 24-step CORDIC and, when it yields an output,
//  one tap per cycle through the single-port delay-line memory.
//  The front and a two-word queue keep taking words while the engine works.
//  Reset clears the NCO, decimation counter and delay-line valid bits at once;
//  no clearing pass is needed. A stalled output holds the engine in its
//  final step; input stalls only when the queue is full.
// ----------------------------------------------------------------------------
module digital_down_converter_unit #(
  parameter int TAP_COUNT      = ddc_pkg::TAP_COUNT_DEF,
  parameter int MAX_DECIMATION = ddc_pkg::MAX_DECIMATION_DEF,
  parameter int SAMPLE_BITS    = ddc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]  in_i_i,
  input  logic signed [SAMPLE_BITS-1:0]  in_q_i,
  input  logic                           block_last_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [ddc_pkg::OUT_W-1:0] out_i_o,
  output logic signed [ddc_pkg::OUT_W-1:0] out_q_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ddc_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ddc_pkg::*;

  localparam int DEC_W = $clog2(MAX_DECIMATION + 1);
  localparam int QW    = 2 * SAMPLE_BITS + $bits(item_ctl_t);

  // configuration registers
  logic [PHASE_W-1:0] phase_step_q;
  logic [DEC_W-1:0]   decim_q;
  logic               wr_en, clear;
  logic [7:0]         dec_raw, dec_sat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign clear  = wr_en && (paddr[2] == REG_DECIM);

  // zero acts as one, anything above the table limit clamps to it
  always_comb begin
    dec_raw = {3'b000, pwdata[4:0]};
    if (dec_raw == 8'd0) dec_sat = 8'd1;
    else if (dec_raw > 8'(MAX_DECIMATION)) dec_sat = 8'(MAX_DECIMATION);
    else dec_sat = dec_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      decim_q      <= DEC_W'(1);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_PHASE_STEP: phase_step_q <= pwdata;
        REG_DECIM:      decim_q      <= dec_sat[DEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PHASE_STEP: prdata = phase_step_q;
      REG_DECIM:      prdata = 32'(decim_q);
      default:        prdata = '0;
    endcase
  end

  // front -> queue -> engine
  logic                   push, full, pop, head_valid;
  logic [SAMPLE_BITS-1:0] push_i, push_q;
  item_ctl_t              push_ctl, head_ctl;
  logic [QW-1:0]          head_data;

  ddc_front #(
    .MAX_DECIMATION (MAX_DECIMATION),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .DEC_W          (DEC_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_i_i       (in_i_i),
    .in_q_i       (in_q_i),
    .block_last_i (block_last_i),
    .phase_step_i (phase_step_q),
    .dec_i        (decim_q),
    .clear_i      (clear),
    .full_i       (full),
    .push_o       (push),
    .push_i_o     (push_i),
    .push_q_o     (push_q),
    .push_ctl_o   (push_ctl)
  );

  ddc_fifo #(
    .W (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_i, push_q, push_ctl}),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_data),
    .valid_o (head_valid)
  );

  assign head_ctl = head_data[$bits(item_ctl_t)-1:0];

  ddc_back #(
    .TAP_COUNT      (TAP_COUNT),
    .MAX_DECIMATION (MAX_DECIMATION),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .DEC_W          (DEC_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i_i     ($signed(head_data[QW-1:QW-SAMPLE_BITS])),
    .head_q_i     ($signed(head_data[QW-SAMPLE_BITS-1:$bits(item_ctl_t)])),
    .head_ctl_i   (head_ctl),
    .pop_o        (pop),
    .dec_i        (decim_q),
    .clear_i      (clear),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_i_o      (out_i_o),
    .out_q_o      (out_q_o)
  );
endmodule

// File: rtl/ddc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddc_fifo: two-entry queue between front and back
// Decouples sample intake from the filter engine.
// ----------------------------------------------------------------------------
module ddc_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         valid_o
);
  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end
endmodule

// File: rtl/ddc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddc_front: sample intake
// Tags each word with its NCO phase and whether it yields an output.
// ----------------------------------------------------------------------------
module ddc_front #(
  parameter int MAX_DECIMATION = 16,
  parameter int SAMPLE_BITS    = 16,
  parameter int DEC_W          = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] in_i_i,
  input  logic signed [SAMPLE_BITS-1:0] in_q_i,
  input  logic                          block_last_i,
  input  logic [ddc_pkg::PHASE_W-1:0]   phase_step_i,
  input  logic [DEC_W-1:0]              dec_i,
  input  logic                          clear_i,
  input  logic                          full_i,
  output logic                          push_o,
  output logic [SAMPLE_BITS-1:0]        push_i_o,
  output logic [SAMPLE_BITS-1:0]        push_q_o,
  output ddc_pkg::item_ctl_t            push_ctl_o
);
  import ddc_pkg::*;

  localparam int CNT_W = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;

  logic [PHASE_W-1:0] phase_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DEC_W:0]     cnt_inc;
  logic               accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;
  assign push_i_o   = in_i_i;
  assign push_q_o   = in_q_i;
  assign push_ctl_o = '{phase: phase_q, produce: (cnt_q == '0)};

  always_comb begin
    cnt_inc = (DEC_W + 1)'(cnt_q) + (DEC_W + 1)'(1);
    if (block_last_i || cnt_inc >= {1'b0, dec_i}) cnt_d = '0;
    else cnt_d = cnt_inc[CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      cnt_q   <= '0;
    end else if (clear_i) begin
      cnt_q <= '0;
    end else if (accept) begin
      phase_q <= phase_q + phase_step_i;
      cnt_q   <= cnt_d;
    end
  end
endmodule

// File: rtl/ddc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddc_back: NCO, mixer and FIR engine
// Iterative CORDIC, mixer, then one tap per cycle over the delay line.
// ----------------------------------------------------------------------------
module ddc_back #(
  parameter int TAP_COUNT      = 65,
  parameter int MAX_DECIMATION = 16,
  parameter int SAMPLE_BITS    = 16,
  parameter int DEC_W          = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  logic signed [SAMPLE_BITS-1:0] head_i_i,
  input  logic signed [SAMPLE_BITS-1:0] head_q_i,
  input  ddc_pkg::item_ctl_t            head_ctl_i,
  output logic                          pop_o,
  input  logic [DEC_W-1:0]              dec_i,
  input  logic                          clear_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [ddc_pkg::OUT_W-1:0] out_i_o,
  output logic signed [ddc_pkg::OUT_W-1:0] out_q_o
);
  import ddc_pkg::*;

  localparam int SB        = SAMPLE_BITS;
  localparam int HIST      = TAP_COUNT - 1;
  localparam int HA        = $clog2(HIST);
  localparam int KW        = $clog2(TAP_COUNT);
  localparam int ROM_DEPTH = MAX_DECIMATION * TAP_COUNT;
  localparam int RA        = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1;
  localparam int PW        = SB + NCO_W;
  localparam int SW        = PW + 1;
  localparam int MP        = SB + TAP_W;
  localparam int AW        = MP + $clog2(TAP_COUNT);
  localparam int SH        = SB - 7;
  localparam longint SMAX  = (longint'(1) << (SB - 1)) - 1;
  localparam longint OMAX  = (longint'(1) << (OUT_W - 1)) - 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CORDIC = 3'd1;
  localparam logic [2:0] ST_NCO    = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_SUM    = 3'd4;
  localparam logic [2:0] ST_FIR    = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  typedef logic signed [TAP_W-1:0] rom_t [ROM_DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int d = 1; d <= MAX_DECIMATION; d++) begin
      for (int n = 0; n < TAP_COUNT; n++) begin
        r[(d - 1) * TAP_COUNT + n] = tap_coef(d, n, TAP_COUNT);
      end
    end
    return r;
  endfunction

  localparam rom_t TAP_ROM = build_rom();

  logic [2:0] state_q;

  // item payload
  logic signed [SB-1:0]       si_q, sq_q;
  logic                       produce_q;
  logic                       flip_q;
  logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
  logic [ITER_W-1:0]          it_q;
  logic signed [NCO_W-1:0]    c_q, s_q;
  logic signed [PW-1:0]       p0_q, p1_q, p2_q, p3_q;
  logic signed [SB-1:0]       re_q, im_q;

  // delay line
  logic [2*SB-1:0] hist_mem [HIST];
  logic [HIST-1:0] hist_vld_q;
  logic [HA-1:0]   wptr_q, rptr_q;

  // FIR sequencing
  logic [KW-1:0]            k_q;
  logic                     issue_done_q;
  logic [RA-1:0]            tidx_q;
  logic                     s1_v_q, s1_last_q, s1_new_q;
  logic [2*SB-1:0]          rd_q;
  logic                     rdv_q;
  logic signed [TAP_W-1:0]  tap_q;
  logic                     s2_v_q, s2_last_q;
  logic signed [MP-1:0]     pi_q, pq_q;
  logic signed [AW-1:0]     acc_i_q, acc_q_q;

  logic                     out_valid_q;
  logic signed [OUT_W-1:0]  out_i_q, out_q_q;

  // combinational helpers
  logic [PHASE_W-1:0]         ph_adj;
  logic                       head_flip;
  logic signed [CORDIC_W-1:0] dx, dy, ang, cf, sf, cr, sr;
  logic signed [NCO_W-1:0]    cn, sn;
  logic signed [SW-1:0]       sre, sim, rre, rim;
  logic signed [SB-1:0]       re_n, im_n;
  logic signed [SB-1:0]       smp_i, smp_q;
  logic signed [AW-1:0]       ro_i, ro_q;
  logic signed [OUT_W-1:0]    oi_n, oq_n;
  logic [RA-1:0]              tbase;
  logic                       out_free, finish_go, fir_start;

  function automatic logic signed [NCO_W-1:0] sat_nco(input logic signed [CORDIC_W-1:0] v);
    if (v > $signed(CORDIC_W'(32767))) return NCO_W'(32767);
    if (v < $signed(-CORDIC_W'(32768))) return NCO_W'(-32768);
    return v[NCO_W-1:0];
  endfunction

  function automatic logic signed [SB-1:0] sat_smp(input logic signed [SW-1:0] v);
    if (v > $signed(SW'(SMAX))) return SB'(SMAX);
    if (v < $signed(-SW'(SMAX) - SW'(1))) return SB'(-SMAX - 1);
    return v[SB-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [AW-1:0] v);
    if (v > $signed(AW'(OMAX))) return OUT_W'(OMAX);
    if (v < $signed(-AW'(OMAX) - AW'(1))) return OUT_W'(-OMAX - 1);
    return v[OUT_W-1:0];
  endfunction

  always_comb begin
    head_flip = (head_ctl_i.phase[31:30] == 2'd1) || (head_ctl_i.phase[31:30] == 2'd2);
    ph_adj    = head_flip ? head_ctl_i.phase + 32'h8000_0000 : head_ctl_i.phase;
    dx  = x_q >>> it_q;
    dy  = y_q >>> it_q;
    ang = $signed(atan_q30(it_q));
    cf  = flip_q ? -x_q : x_q;
    sf  = flip_q ? -y_q : y_q;
    cr  = (cf + CORDIC_W'(16384)) >>> 15;
    sr  = (sf + CORDIC_W'(16384)) >>> 15;
    cn  = sat_nco(cr);
    sn  = sat_nco(sr);
    sre = SW'(p0_q) - SW'(p1_q);
    sim = SW'(p2_q) + SW'(p3_q);
    rre = (sre + SW'(16384)) >>> 15;
    rim = (sim + SW'(16384)) >>> 15;
    re_n = sat_smp(rre);
    im_n = sat_smp(rim);
    smp_i = s1_new_q ? re_q : (rdv_q ? $signed(rd_q[2*SB-1:SB]) : '0);
    smp_q = s1_new_q ? im_q : (rdv_q ? $signed(rd_q[SB-1:0]) : '0);
    ro_i = (acc_i_q + (AW'(1) << (SH - 1))) >>> SH;
    ro_q = (acc_q_q + (AW'(1) << (SH - 1))) >>> SH;
    oi_n = sat_out(ro_i);
    oq_n = sat_out(ro_q);
    tbase = RA'((RA'(dec_i) - RA'(1)) * RA'(TAP_COUNT));
    out_free  = !out_valid_q || !out_stall_i;
    finish_go = (state_q == ST_FINISH) && (!produce_q || out_free);
    fir_start = (state_q == ST_SUM) && produce_q;
  end

  assign pop_o       = (state_q == ST_IDLE) && head_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_i_o     = out_i_q;
  assign out_q_o     = out_q_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      it_q         <= '0;
      hist_vld_q   <= '0;
      wptr_q       <= '0;
      issue_done_q <= 1'b0;
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      s1_v_q <= (state_q == ST_FIR) && !issue_done_q;
      s2_v_q <= s1_v_q;
      unique case (state_q)
        ST_IDLE: begin
          if (head_valid_i) begin
            state_q <= ST_CORDIC;
            it_q    <= '0;
          end
        end
        ST_CORDIC: begin
          it_q <= it_q + ITER_W'(1);
          if (it_q == ITER_W'(CORDIC_ITERS - 1)) state_q <= ST_NCO;
        end
        ST_NCO: state_q <= ST_MUL;
        ST_MUL: state_q <= ST_SUM;
        ST_SUM: begin
          state_q      <= produce_q ? ST_FIR : ST_FINISH;
          issue_done_q <= 1'b0;
        end
        ST_FIR: begin
          if (!issue_done_q && k_q == KW'(HIST)) issue_done_q <= 1'b1;
          if (s2_v_q && s2_last_q) state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (finish_go) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      // a new word may replace the one taken this edge
      if (finish_go && produce_q) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (clear_i) begin
        hist_vld_q <= '0;
        wptr_q     <= '0;
      end else if (finish_go) begin
        hist_vld_q[wptr_q] <= 1'b1;
        wptr_q <= (wptr_q == HA'(HIST - 1)) ? '0 : wptr_q + HA'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      si_q      <= head_i_i;
      sq_q      <= head_q_i;
      produce_q <= head_ctl_i.produce;
      flip_q    <= head_flip;
      x_q       <= CORDIC_W'(CORDIC_GAIN_Q30);
      y_q       <= '0;
      z_q       <= CORDIC_W'(signed'(ph_adj));
    end
    if (state_q == ST_CORDIC) begin
      if (!z_q[CORDIC_W-1]) begin
        x_q <= x_q - dy; y_q <= y_q + dx; z_q <= z_q - ang;
      end else begin
        x_q <= x_q + dy; y_q <= y_q - dx; z_q <= z_q + ang;
      end
    end
    if (state_q == ST_NCO) begin
      c_q <= cn;
      s_q <= sn;
    end
    if (state_q == ST_MUL) begin
      p0_q <= si_q * c_q;
      p1_q <= sq_q * s_q;
      p2_q <= si_q * s_q;
      p3_q <= sq_q * c_q;
    end
    if (state_q == ST_SUM) begin
      re_q <= re_n;
      im_q <= im_n;
    end
    if (fir_start) begin
      k_q     <= '0;
      rptr_q  <= wptr_q;
      tidx_q  <= tbase;
      acc_i_q <= '0;
      acc_q_q <= '0;
    end else if (state_q == ST_FIR) begin
      if (!issue_done_q) begin
        k_q    <= k_q + KW'(1);
        tidx_q <= tidx_q + RA'(1);
        rptr_q <= (rptr_q == HA'(HIST - 1)) ? '0 : rptr_q + HA'(1);
      end
      if (s2_v_q) begin
        acc_i_q <= acc_i_q + AW'(pi_q);
        acc_q_q <= acc_q_q + AW'(pq_q);
      end
    end
    // tap issue stage
    rd_q      <= hist_mem[rptr_q];
    rdv_q     <= hist_vld_q[rptr_q];
    tap_q     <= TAP_ROM[tidx_q];
    s1_last_q <= (k_q == KW'(HIST));
    s1_new_q  <= (k_q == KW'(HIST));
    // multiply stage
    pi_q      <= smp_i * tap_q;
    pq_q      <= smp_q * tap_q;
    s2_last_q <= s1_last_q;
    if (finish_go) begin
      hist_mem[wptr_q] <= {re_q, im_q};
      if (produce_q) begin
        out_i_q <= oi_n;
        out_q_q <= oq_n;
      end
    end
  end
endmodule

// File: tb/ddc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddc_checker: down-converter prediction and compare
// Watches the APB writes and both streaming channels, predicts each output
// word from its own NCO, mixer and FIR model, and checks it in order.
// ----------------------------------------------------------------------------
module ddc_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic signed [15:0]        in_i_i,
  input  logic signed [15:0]        in_q_i,
  input  logic                      block_last_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [23:0]        out_i_i,
  input  logic signed [23:0]        out_q_i,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic                      pready_i,
  input  logic [2:0]                paddr_i,
  input  logic [31:0]               pwdata_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  localparam int NTAPS = 65;
  localparam int HIST  = NTAPS - 1;
  localparam int DMAX  = 16;
  localparam logic [2:0] ADDR_STEP  = 3'd0;
  localparam logic [2:0] ADDR_DECIM = 3'd4;

  localparam longint GAIN_Q30   = 652032874;
  localparam longint INVPI_Q30  = 341782638;
  localparam longint HAMA_Q30   = 579820585;
  localparam longint HAMB_Q30   = 493921239;

  typedef struct {
    logic signed [23:0] i;
    logic signed [23:0] q;
  } iq_word_t;

  longint atan_q30 [16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                            21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                            333772, 166886, 83443, 41722, 20861};

  longint      coef [DMAX][NTAPS];
  logic [31:0] step_word;
  int          decim;
  logic [31:0] phase_acc;
  int          decim_ctr;
  longint      hist_re [HIST];
  longint      hist_im [HIST];
  iq_word_t    expected_iq [$];
  int          fails;

  function automatic longint round_sh(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(input longint v, input int bits);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // quadrant-folded rotation CORDIC, Q2.30 out
  function automatic void sincos(input logic [31:0] ph, output longint c, output longint s);
    bit     flip;
    longint x, y, z, a, dx, dy;
    flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
    if (flip) ph = ph + 32'h8000_0000;
    z = longint'($signed(ph));
    x = GAIN_Q30;
    y = 0;
    for (int k = 0; k < 24; k++) begin
      a  = k < 16 ? atan_q30[k] : (longint'(683565276) >>> k);
      dx = x >>> k;
      dy = y >>> k;
      if (z >= 0) begin
        x = x - dy; y = y + dx; z = z - a;
      end else begin
        x = x + dy; y = y - dx; z = z + a;
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic void build_coef();
    longint m, am, sinc, c30, s30, w, h;
    longint unsigned ph;
    for (int d = 1; d <= DMAX; d++) begin
      for (int n = 0; n < NTAPS; n++) begin
        m  = n - HIST / 2;
        am = m < 0 ? -m : m;
        if (m == 0) begin
          sinc = ((longint'(1) << 30) + d / 2) / d;
        end else begin
          ph = ((longint'(am) << 32) + d) / (2 * d);
          sincos(ph[31:0], c30, s30);
          sinc = round_sh(s30 * INVPI_Q30, 30) / am;
        end
        ph = ((longint'(n) << 32) + HIST / 2) / HIST;
        sincos(ph[31:0], c30, s30);
        w = HAMA_Q30 - round_sh(HAMB_Q30 * c30, 30);
        h = round_sh(sinc * w, 30);
        coef[d-1][n] = clip(round_sh(h, 13), 18);
      end
    end
  endfunction

  initial build_coef();

  // one sample through the mixer and the delay line; returns 1 on output
  function automatic bit mix_and_filter(input longint si, input longint sq,
                                        input bit last, output iq_word_t w);
    longint c30, s30, c, s, re, im, acc_i, acc_q;
    bit     hit;
    sincos(phase_acc, c30, s30);
    c  = clip(round_sh(c30, 15), 16);
    s  = clip(round_sh(s30, 15), 16);
    re = clip(round_sh(si * c - sq * s, 15), 16);
    im = clip(round_sh(si * s + sq * c, 15), 16);
    phase_acc = phase_acc + step_word;
    hit = (decim_ctr == 0);
    if (hit) begin
      acc_i = re * coef[decim-1][HIST];
      acc_q = im * coef[decim-1][HIST];
      for (int k = 0; k < HIST; k++) begin
        acc_i += hist_re[k] * coef[decim-1][k];
        acc_q += hist_im[k] * coef[decim-1][k];
      end
      w.i = 24'(clip(round_sh(acc_i, 9), 24));
      w.q = 24'(clip(round_sh(acc_q, 9), 24));
    end
    for (int k = 0; k < HIST - 1; k++) begin
      hist_re[k] = hist_re[k+1];
      hist_im[k] = hist_im[k+1];
    end
    hist_re[HIST-1] = re;
    hist_im[HIST-1] = im;
    if (last || decim_ctr + 1 >= decim) decim_ctr = 0;
    else decim_ctr++;
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    iq_word_t nw, ew;
    int       v;
    if (!rst_ni) begin
      step_word <= '0;
      decim     = 1;
      phase_acc = '0;
      decim_ctr = 0;
      foreach (hist_re[k]) begin
        hist_re[k] = 0;
        hist_im[k] = 0;
      end
      expected_iq.delete();
      fails = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == ADDR_STEP[2]) begin
          step_word <= pwdata_i;
        end else if (paddr_i[2] == ADDR_DECIM[2]) begin
          v = int'(pwdata_i[4:0]);
          decim = v < 1 ? 1 : (v > DMAX ? DMAX : v);
          decim_ctr = 0;
          foreach (hist_re[k]) begin
            hist_re[k] = 0;
            hist_im[k] = 0;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (mix_and_filter(longint'(in_i_i), longint'(in_q_i), block_last_i, nw))
          expected_iq = {expected_iq, nw};
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_iq.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected output word i=%0d q=%0d", out_i_i, out_q_i);
        end else begin
          ew = expected_iq.pop_front();
          if (ew.i !== out_i_i || ew.q !== out_q_i) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected i=%0d q=%0d, got i=%0d q=%0d",
                       ew.i, ew.q, out_i_i, out_q_i);
          end
        end
      end
    end
  end

  // a non-blocking step update keeps the mixer on the old step this edge
  always_comb fail_count_o = fails;
  always_comb pending_o    = expected_iq.size();

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: down-converter testbench top
// Drives directed and random I/Q words and APB register writes through
// several idling phases; the checker predicts and compares every output.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [2:0] ADDR_STEP  = 3'd0;
  localparam logic [2:0] ADDR_DECIM = 3'd4;
  localparam int WATCHDOG_LIMIT = 6000;
  // items with no output can still be in the engine: queue of two plus one
  localparam int DRAIN_CYCLES   = 400;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] in_i_i;
  logic signed [15:0] in_q_i;
  logic               block_last_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [23:0] out_i_o;
  logic signed [23:0] out_q_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;
  int send_idle_pct;   // sender idles this often, percent
  int recv_stall_pct;  // receiver stalls this often, percent
  bit recv_hold;       // long receiver hold-off
  int quiet_cycles;

  digital_down_converter_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_i_i       (in_i_i),
    .in_q_i       (in_q_i),
    .block_last_i (block_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_i_o      (out_i_o),
    .out_q_o      (out_q_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  ddc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_i_i       (in_i_i),
    .in_q_i       (in_q_i),
    .block_last_i (block_last_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_i_i      (out_i_o),
    .out_q_i      (out_q_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stall, or a solid hold-off when asked
  always @(posedge clk_i) begin
    out_stall_i <= recv_hold || ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watchdog: counts edges where nothing moves on any port
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("digital_down_converter_unit verification failed");
      $finish;
    end
  end

  // APB write: setup cycle and access cycle, then the bus goes idle
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one word; stall is sampled mid-cycle, where it is stable
  task automatic send_word(input logic [15:0] si, input logic [15:0] sq, input bit last);
    bit stalled;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_i_i       <= si;
    in_q_i       <= sq;
    block_last_i <= last;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  // mostly full-range samples, with frequent rail values
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom());
    endcase
  endfunction

  // idle phase boundary: every output in, then the engine drained
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_burst(input int count);
    for (int k = 0; k < count; k++)
      send_word(pick_sample(), pick_sample(), $urandom_range(0, 19) == 0);
  endtask

  initial begin
    int decims [6] = '{1, 16, 2, 5, 8, 13};
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_i_i         = '0;
    in_q_i         = '0;
    block_last_i   = 1'b0;
    out_stall_i    = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold      = 1'b0;
    quiet_cycles   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config, unity decimation, rails and block ends
    send_word(16'h7fff, 16'h7fff, 1'b0);
    send_word(16'h8000, 16'h8000, 1'b0);
    send_word(16'h7fff, 16'h8000, 1'b1);
    send_word(16'h8000, 16'h7fff, 1'b0);
    send_word(16'h0000, 16'h0000, 1'b1);
    send_word(16'hffff, 16'h0001, 1'b0);
    settle();

    // quarter-turn step, widest decimation; block end resets the count
    reg_write(ADDR_STEP, 32'h4000_0000);
    reg_write(ADDR_DECIM, 32'd16);
    for (int k = 0; k < 6; k++) send_word(16'h7fff, 16'h8000, k == 2);
    settle();

    // decimation zero acts as one; most-negative step
    reg_write(ADDR_STEP, 32'h8000_0000);
    reg_write(ADDR_DECIM, 32'd0);
    for (int k = 0; k < 4; k++) send_word(16'h8000, 16'h8000, 1'b0);
    settle();

    // decimation above the maximum saturates; most-positive step
    reg_write(ADDR_STEP, 32'h7fff_ffff);
    reg_write(ADDR_DECIM, 32'hffff_ff1f);
    for (int k = 0; k < 6; k++) send_word(16'h7fff, 16'h7fff, 1'b0);
    settle();

    // random phases: none, sender idle, receiver stall, both light
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(ADDR_STEP, $urandom());
      reg_write(ADDR_DECIM, {27'($urandom_range(0, 32'h7ff_ffff)), 5'(decims[ph])});
      send_idle_pct  = ph == 1 ? 84 : (ph == 3 ? 12 : 0);
      recv_stall_pct = ph == 2 ? 84 : (ph == 3 ? 12 : 0);
      random_burst(130);
      settle();
    end

    // pressure: receiver holds off while words keep coming; queue fills
    reg_write(ADDR_STEP, $urandom());
    reg_write(ADDR_DECIM, 32'(decims[$urandom_range(2, 5)]));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (1500) @(posedge clk_i);
        recv_hold = 1'b0;
      end
    join_none
    random_burst(110);
    settle();

    if (fail_count == 0) begin
      $display("digital_down_converter_unit verification clean");
    end else begin
      $display("digital_down_converter_unit verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ddc_pkg.sv
rtl/ddc_fifo.sv
rtl/ddc_front.sv
rtl/ddc_back.sv
rtl/digital_down_converter_unit.sv
tb/ddc_checker.sv
tb/tb.sv
